// ===== rtl/security_association_lookup_core_macros.svh =====
// Assertion macros for the security association lookup core checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SECURITY_ASSOCIATION_LOOKUP_CORE_MACROS_SVH
`define SECURITY_ASSOCIATION_LOOKUP_CORE_MACROS_SVH

// same-cycle implication
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sal_pkg.sv =====
// Shared types and constants of the security association lookup core.
// No dependencies.
`default_nettype none

package sal_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_INBOUND  = 3'd2,
    OP_OUTBOUND = 3'd3,
    OP_FLUSH    = 3'd4
  } sal_op_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DUP       = 3'd3,
    STAT_NOT_IPSEC = 3'd4
  } sal_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } sal_state_t;

  localparam logic [7:0] PROTO_ESP = 8'd50;
  localparam logic [7:0] PROTO_AH  = 8'd51;
  localparam logic [7:0] PROTO_ANY = 8'd0;
  localparam logic [5:0] PFX_FULL  = 6'd32;

  typedef struct packed {
    sal_op_t     op;
    logic [31:0] spi;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic        kind;
    logic [1:0]  mode;
    logic [5:0]  slen;
    logic [5:0]  dlen;
    logic [15:0] tag;
  } sal_req_t;

  // one stored table entry, tag kept separately
  typedef struct packed {
    logic [31:0] spi;
    logic [31:0] dst;
    logic [31:0] src;
    logic [7:0]  proto;
    logic        kind;
    logic [1:0]  mode;
    logic [5:0]  slen;
    logic [5:0]  dlen;
  } sal_entry_t;

  typedef struct packed {
    logic key_eq;   // spi, dst and protocol equal
    logic key0_eq;  // spi and dst equal, entry protocol wildcard
    logic sel_eq;   // outbound selector match
  } sal_match_t;

  // network prefix mask; 0 matches all, above 32 counts as 32
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= PFX_FULL) begin
      m = 32'hffff_ffff;
    end else begin
      m = 32'hffff_ffff << (PFX_FULL - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sal_table.sv =====
// Entry storage of the security association table: one write port,
// one registered read port. Depends on sal_pkg.
`default_nettype none

module sal_table #(
  parameter int DEPTH    = 64,
  parameter int AW       = 6,
  parameter int TAG_BITS = 16
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [AW-1:0]            wr_addr,
  input  wire sal_pkg::sal_entry_t wr_entry,
  input  wire  [TAG_BITS-1:0]      wr_tag,
  input  wire                      rd_en,
  input  wire  [AW-1:0]            rd_addr,
  output sal_pkg::sal_entry_t      rd_entry,
  output logic [TAG_BITS-1:0]      rd_tag
);

  sal_pkg::sal_entry_t     ent_mem [DEPTH];
  logic [TAG_BITS-1:0]     tag_mem [DEPTH];
  sal_pkg::sal_entry_t     rd_entry_r;
  logic [TAG_BITS-1:0]     rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= wr_entry;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= ent_mem[rd_addr];
      rd_tag_r   <= tag_mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_tag   = rd_tag_r;

endmodule

`default_nettype wire

// ===== rtl/sal_match.sv =====
// Compare unit: checks one table entry against the held request.
// Depends on sal_pkg.
`default_nettype none

module sal_match (
  input  wire sal_pkg::sal_req_t   req,
  input  wire sal_pkg::sal_entry_t ent,
  output sal_pkg::sal_match_t      res
);

  logic        addr_eq;
  logic [31:0] smask;
  logic [31:0] dmask;

  assign addr_eq = (ent.spi == req.spi) && (ent.dst == req.dst);
  assign smask   = sal_pkg::prefix_mask(ent.slen);
  assign dmask   = sal_pkg::prefix_mask(ent.dlen);

  assign res.key_eq  = addr_eq && (ent.proto == req.proto);
  assign res.key0_eq = addr_eq && (ent.proto == sal_pkg::PROTO_ANY);
  assign res.sel_eq  = (ent.kind == req.kind) && (ent.mode == req.mode) &&
                       ((ent.src & smask) == (req.src & smask)) &&
                       ((ent.dst & dmask) == (req.dst & dmask));

endmodule

`default_nettype wire

// ===== rtl/security_association_lookup_core.sv =====
// Security association lookup core: one request at a time, table scanned
// one entry per cycle through a registered-read memory and one compare unit.
// Insert/remove/lookup scan the whole table, or stop early on a match; flush,
// unknown and non-ESP/AH inbound requests answer without a scan. A new request
// is taken only once the result has been accepted. Reset (sync, active low)
// invalidates all entries.
`default_nettype none

module security_association_lookup_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int TAG_BITS      = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // spi, src_addr, dst_addr, protocol, sa_kind, mode, src_prefix_len,
  // dst_prefix_len, sa_tag, zero pad
  input  wire  [135:0] in_tdata,
  // req_type
  input  wire  [2:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // entry_index, found_tag, zero pad
  output logic [23:0]  out_tdata,
  // hit, status
  output logic [3:0]   out_tuser
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW:0]   CNT_DEPTH = (AW+1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_ENTRIES - 1);

  sal_pkg::sal_state_t state_r, state_nxt;
  sal_pkg::sal_req_t   req_r, req_nxt, in_req;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [AW:0]         rd_cnt_r, rd_cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                free_found_r, free_found_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic                k0_found_r, k0_found_nxt;
  logic [AW-1:0]       k0_idx_r, k0_idx_nxt;
  logic [TAG_BITS-1:0] k0_tag_r, k0_tag_nxt;

  logic                hit_r, hit_nxt;
  sal_pkg::sal_status_t status_r, status_nxt;
  logic [5:0]          index_r, index_nxt;
  logic [15:0]         tag_r, tag_nxt;

  logic                in_acc, in_imm, in_ipsec;
  logic                mem_wr_en, mem_rd_en;
  logic [AW-1:0]       mem_wr_addr;
  sal_pkg::sal_entry_t wr_entry, rd_entry;
  logic [TAG_BITS-1:0] rd_tag;
  sal_pkg::sal_match_t mres;

  logic cur_valid, stop_hit, last_cmp, scan_done;
  logic free_now, free_any, k0_now, k0_any;
  logic [AW-1:0] free_sel, k0_sel;
  logic [TAG_BITS-1:0] k0_tag_sel;

  // request unpack
  always_comb begin
    in_req.op    = sal_pkg::sal_op_t'(in_tuser[2:0]);
    in_req.spi   = in_tdata[31:0];
    in_req.src   = in_tdata[63:32];
    in_req.dst   = in_tdata[95:64];
    in_req.proto = in_tdata[103:96];
    in_req.kind  = in_tdata[104];
    in_req.mode  = in_tdata[106:105];
    in_req.slen  = in_tdata[112:107];
    in_req.dlen  = in_tdata[118:113];
    in_req.tag   = in_tdata[134:119];
  end

  assign in_acc   = in_tvalid && in_tready;
  assign in_ipsec = (in_req.proto == sal_pkg::PROTO_ESP) ||
                    (in_req.proto == sal_pkg::PROTO_AH);

  always_comb begin
    case (in_req.op)
      sal_pkg::OP_INSERT,
      sal_pkg::OP_REMOVE,
      sal_pkg::OP_OUTBOUND: in_imm = 1'b0;
      sal_pkg::OP_INBOUND:  in_imm = !in_ipsec;
      default:              in_imm = 1'b1;
    endcase
  end

  sal_table #(
    .DEPTH    (TABLE_ENTRIES),
    .AW       (AW),
    .TAG_BITS (TAG_BITS)
  ) u_table (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_entry (wr_entry),
    .wr_tag   (TAG_BITS'(req_r.tag)),
    .rd_en    (mem_rd_en),
    .rd_addr  (rd_cnt_r[AW-1:0]),
    .rd_entry (rd_entry),
    .rd_tag   (rd_tag)
  );

  sal_match u_match (
    .req (req_r),
    .ent (rd_entry),
    .res (mres)
  );

  always_comb begin
    wr_entry.spi   = req_r.spi;
    wr_entry.dst   = req_r.dst;
    wr_entry.src   = req_r.src;
    wr_entry.proto = req_r.proto;
    wr_entry.kind  = req_r.kind;
    wr_entry.mode  = req_r.mode;
    wr_entry.slen  = req_r.slen;
    wr_entry.dlen  = req_r.dlen;
  end

  // scan evaluation of the entry now on the read port
  assign cur_valid = cmp_vld_r && valid_r[cmp_idx_r];
  assign last_cmp  = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign free_now  = cmp_vld_r && !valid_r[cmp_idx_r];
  assign free_any  = free_found_r || free_now;
  assign free_sel  = free_found_r ? free_idx_r : cmp_idx_r;
  assign k0_now    = cur_valid && mres.key0_eq;
  assign k0_any    = k0_found_r || k0_now;
  assign k0_sel    = k0_found_r ? k0_idx_r : cmp_idx_r;
  assign k0_tag_sel = k0_found_r ? k0_tag_r : rd_tag;

  always_comb begin
    case (req_r.op)
      sal_pkg::OP_INSERT,
      sal_pkg::OP_REMOVE,
      sal_pkg::OP_INBOUND:  stop_hit = cur_valid && mres.key_eq;
      sal_pkg::OP_OUTBOUND: stop_hit = cur_valid && mres.sel_eq;
      default:              stop_hit = 1'b0;
    endcase
  end

  assign scan_done = (state_r == sal_pkg::S_SCAN) && (stop_hit || last_cmp);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sal_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_imm ? sal_pkg::S_RESP : sal_pkg::S_SCAN;
        end
      end
      sal_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = sal_pkg::S_RESP;
        end
      end
      sal_pkg::S_RESP: begin
        if (out_tready) begin
          state_nxt = sal_pkg::S_IDLE;
        end
      end
      default: state_nxt = sal_pkg::S_IDLE;
    endcase
  end

  // handshake outputs and read issue
  always_comb begin
    in_tready  = (state_r == sal_pkg::S_IDLE);
    out_tvalid = (state_r == sal_pkg::S_RESP);
    mem_rd_en  = (state_r == sal_pkg::S_SCAN) && (rd_cnt_r < CNT_DEPTH);
    out_tdata  = {2'b00, tag_r, index_r};
    out_tuser  = {status_r, hit_r};
  end

  // datapath
  always_comb begin
    req_nxt        = req_r;
    valid_nxt      = valid_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    k0_found_nxt   = k0_found_r;
    k0_idx_nxt     = k0_idx_r;
    k0_tag_nxt     = k0_tag_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    index_nxt      = index_r;
    tag_nxt        = tag_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = free_sel;

    if ((state_r == sal_pkg::S_IDLE) && in_acc) begin
      req_nxt        = in_req;
      rd_cnt_nxt     = '0;
      cmp_vld_nxt    = 1'b0;
      free_found_nxt = 1'b0;
      k0_found_nxt   = 1'b0;
      hit_nxt        = 1'b0;
      status_nxt     = sal_pkg::STAT_NOT_FOUND;
      index_nxt      = '0;
      tag_nxt        = '0;
      case (in_req.op)
        sal_pkg::OP_FLUSH: begin
          valid_nxt  = '0;
          hit_nxt    = 1'b1;
          status_nxt = sal_pkg::STAT_OK;
        end
        sal_pkg::OP_INBOUND: begin
          if (!in_ipsec) begin
            status_nxt = sal_pkg::STAT_NOT_IPSEC;
          end
        end
        default: begin
        end
      endcase
    end

    if (state_r == sal_pkg::S_SCAN) begin
      cmp_vld_nxt = mem_rd_en;
      cmp_idx_nxt = rd_cnt_r[AW-1:0];
      if (mem_rd_en) begin
        rd_cnt_nxt = rd_cnt_r + (AW+1)'(1);
      end
      if (!free_found_r && free_now) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = cmp_idx_r;
      end
      if (!k0_found_r && k0_now) begin
        k0_found_nxt = 1'b1;
        k0_idx_nxt   = cmp_idx_r;
        k0_tag_nxt   = rd_tag;
      end

      if (scan_done) begin
        hit_nxt    = 1'b0;
        status_nxt = sal_pkg::STAT_NOT_FOUND;
        index_nxt  = '0;
        tag_nxt    = '0;
        if (stop_hit) begin
          case (req_r.op)
            sal_pkg::OP_INSERT: begin
              status_nxt = sal_pkg::STAT_DUP;
            end
            sal_pkg::OP_REMOVE: begin
              valid_nxt[cmp_idx_r] = 1'b0;
              hit_nxt    = 1'b1;
              status_nxt = sal_pkg::STAT_OK;
              index_nxt  = 6'(cmp_idx_r);
              tag_nxt    = 16'(rd_tag);
            end
            default: begin
              hit_nxt    = 1'b1;
              status_nxt = sal_pkg::STAT_OK;
              index_nxt  = 6'(cmp_idx_r);
              tag_nxt    = 16'(rd_tag);
            end
          endcase
        end else begin
          case (req_r.op)
            sal_pkg::OP_INSERT: begin
              if (free_any) begin
                mem_wr_en           = 1'b1;
                valid_nxt[free_sel] = 1'b1;
                hit_nxt             = 1'b1;
                status_nxt          = sal_pkg::STAT_OK;
                index_nxt           = 6'(free_sel);
              end else begin
                status_nxt = sal_pkg::STAT_FULL;
              end
            end
            sal_pkg::OP_INBOUND: begin
              if (k0_any) begin
                hit_nxt    = 1'b1;
                status_nxt = sal_pkg::STAT_OK;
                index_nxt  = 6'(k0_sel);
                tag_nxt    = 16'(k0_tag_sel);
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sal_pkg::S_IDLE;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      k0_found_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      k0_found_r   <= k0_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    k0_idx_r   <= k0_idx_nxt;
    k0_tag_r   <= k0_tag_nxt;
    hit_r      <= hit_nxt;
    status_r   <= status_nxt;
    index_r    <= index_nxt;
    tag_r      <= tag_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sal_checker.sv =====
// Port-level checker for the security association lookup core, bound to it.
// Depends on security_association_lookup_core_macros.svh.
`default_nettype none
`include "security_association_lookup_core_macros.svh"

module sal_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [23:0]  out_tdata,
  input wire [3:0]   out_tuser
);

  // one request in flight at a time
  `SAL_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready after accept")
  `SAL_ASSERT_NOW(a_no_overlap, out_tvalid, !in_tready, "ready while result pending")
  `SAL_ASSERT_NOW(a_hit_ok, out_tvalid && out_tuser[0], out_tuser[3:1] == 3'd0, "hit without ok")
  `SAL_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser[0], out_tdata[21:0] == 22'd0, "miss data")
  `SAL_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind security_association_lookup_core sal_checker u_sal_checker (.*);

`default_nettype wire
